/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the coverage statistics RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while the synchronous reset is active.
`define SMS_ASSERT(LBL, CLK, RST_N, PROP, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RST_N) PROP) \
        else $error(MSG);

// Clocked check that a condition holds at every edge outside reset.
`define SMS_ASSERT_HI(LBL, CLK, RST_N, COND, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RST_N) (COND)) \
        else $error(MSG);

`endif

/* rtl/sms_pkg.sv */
// ----------------------------------------------------------------------------
// sms_pkg
// Shared constants, types and register indexes of the coverage statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sms_pkg;

    localparam int MAX_SAMPLES = 32;
    // Number of counter cells; the sample fields carry at most 32 samples.
    localparam int NCELL       = (MAX_SAMPLES < 32) ? MAX_SAMPLES : 32;
    localparam int PCNT_W      = $clog2(NCELL + 1);

    localparam int TOT_W       = 6;
    localparam int W_W         = 17;
    localparam int BITS_W      = 32;
    localparam int CNT_W       = 32;
    localparam int REAL_W      = 32;
    localparam int WLEN_W      = 48;
    localparam int ACC_W       = 40;
    localparam int DELTA_W     = 8;
    localparam int IDX_W       = 5;
    localparam int RATIO_W     = 17;
    localparam int DIV_STEPS   = 16;
    localparam int STEP_W      = $clog2(DIV_STEPS + 2);

    localparam logic [RATIO_W-1:0] Q16_ONE = 17'h10000;

    localparam int S_TDATA_W   = ((W_W + 2 * BITS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((IDX_W + CNT_W + REAL_W + WLEN_W + RATIO_W + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_UNKNOWN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTGROUP_PRESENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SAMPLES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTGROUP_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTI_POPULATION = 3'd4;

    typedef enum logic [2:0] {
        S_RUN,
        S_WAIT,
        S_PREP,
        S_DIV,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic             cnt;
        logic [W_W-1:0]   weight;
        logic [NCELL-1:0] pres;
    } t_pos;

    typedef struct packed {
        logic             multi;
        logic [TOT_W-1:0] tot;
        logic [TOT_W-1:0] og;
        logic [TOT_W-1:0] ing;
    } t_geom;

endpackage

/* rtl/sms_cell.sv */
// ----------------------------------------------------------------------------
// sms_cell
// One per-sample counter cell of the chain; shifts toward cell zero on drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sms_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sms_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_inc,
    input  logic [sms_pkg::CNT_W-1:0]  i_next,
    output logic [sms_pkg::CNT_W-1:0]  o_count
);
    import sms_pkg::*;

    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
        end else if (i_ctrl.shift) begin
            r_count <= i_next;
        end else if (i_inc) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_count = r_count;

endmodule

/* rtl/sms_tally.sv */
// ----------------------------------------------------------------------------
// sms_tally
// Group presence counts and the length, missing and pair accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sms_tally (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sms_pkg::t_pos               i_pos,
    input  sms_pkg::t_geom              i_geom,
    input  logic                        i_clear,
    output logic                        o_last_done,
    output logic [sms_pkg::REAL_W-1:0]  o_real,
    output logic [sms_pkg::WLEN_W-1:0]  o_wlen,
    output logic [sms_pkg::ACC_W-1:0]   o_missing,
    output logic [sms_pkg::ACC_W-1:0]   o_pair
);
    import sms_pkg::*;

    logic [NCELL-1:0]   w_ing_mask;
    logic [PCNT_W-1:0]  w_x;
    logic [PCNT_W-1:0]  w_y;

    logic               r_vld;
    logic               r_last;
    logic               r_cnt;
    logic [W_W-1:0]     r_w;
    logic [PCNT_W-1:0]  r_x;
    logic [PCNT_W-1:0]  r_y;

    logic               w_both;
    logic [DELTA_W-1:0] w_dm;
    logic [DELTA_W-1:0] w_dp;

    logic [REAL_W-1:0]  r_real;
    logic [WLEN_W-1:0]  r_wlen;
    logic [ACC_W-1:0]   r_missing;
    logic [ACC_W-1:0]   r_pair;

    // The sample bits arrive already masked to the samples in use, so the
    // outgroup count is everything at or above the ingroup size.
    always_comb begin
        for (int n = 0; n < NCELL; n++) begin
            w_ing_mask[n] = (TOT_W'(n) < i_geom.ing);
        end
        w_x = PCNT_W'($countones(i_pos.pres & w_ing_mask));
        w_y = PCNT_W'($countones(i_pos.pres & ~w_ing_mask));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_vld  <= i_pos.vld;
            r_last <= i_pos.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= i_pos.cnt;
        r_w   <= i_pos.weight;
        r_x   <= w_x;
        r_y   <= w_y;
    end

    // Missing and pair deltas are small; they wrap in DELTA_W bits and are
    // sign-extended into the 40-bit totals.
    always_comb begin
        if (i_geom.multi) begin
            w_both = (r_x != '0) && (r_y != '0);
            w_dm   = w_both ? (DELTA_W'(i_geom.ing) - DELTA_W'(r_x)) : '0;
            w_dp   = w_both ? DELTA_W'(i_geom.ing) : '0;
        end else begin
            w_both = (r_y != '0);
            if (w_both) begin
                w_dm = DELTA_W'(i_geom.og) - DELTA_W'(r_y);
                w_dp = DELTA_W'(i_geom.og);
            end else begin
                w_dm = DELTA_W'(i_geom.og) - DELTA_W'(i_geom.ing) + DELTA_W'(1)
                       - DELTA_W'(i_geom.tot);
                w_dp = DELTA_W'(i_geom.og) - DELTA_W'(i_geom.ing) - DELTA_W'(i_geom.tot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real    <= '0;
            r_wlen    <= '0;
            r_missing <= '0;
            r_pair    <= '0;
        end else if (i_clear) begin
            r_real    <= '0;
            r_wlen    <= '0;
            r_missing <= '0;
            r_pair    <= '0;
        end else if (r_vld && r_cnt) begin
            if (w_both) begin
                r_real <= r_real + REAL_W'(1);
                r_wlen <= r_wlen + WLEN_W'(r_w);
            end
            r_missing <= r_missing + {{(ACC_W - DELTA_W){w_dm[DELTA_W-1]}}, w_dm};
            r_pair    <= r_pair + {{(ACC_W - DELTA_W){w_dp[DELTA_W-1]}}, w_dp};
        end
    end

    assign o_last_done = r_vld && r_last;
    assign o_real      = r_real;
    assign o_wlen      = r_wlen;
    assign o_missing   = r_missing;
    assign o_pair      = r_pair;

    `SMS_ASSERT(a_clear_zeroes, i_clk, i_rst_n, i_clear |=> (o_real == '0 && o_wlen == '0 && o_missing == '0 && o_pair == '0), "totals not cleared after drain")

endmodule

/* rtl/sms_ratio.sv */
// ----------------------------------------------------------------------------
// sms_ratio
// Missing-over-pairs ratio in Q16 by a restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sms_ratio (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sms_pkg::ACC_W-1:0]    i_missing,
    input  logic [sms_pkg::ACC_W-1:0]    i_pair,
    output logic                         o_done,
    output logic [sms_pkg::RATIO_W-1:0]  o_ratio
);
    import sms_pkg::*;

    localparam logic [STEP_W-1:0] STEP_DECIDE = STEP_W'(DIV_STEPS + 1);

    logic [STEP_W-1:0]    r_step;
    logic                 r_done;
    logic                 r_pz;
    logic                 r_neg_m;
    logic                 r_neg_p;
    logic [ACC_W-1:0]     r_mag_m;
    logic [ACC_W-1:0]     r_mag_p;
    logic [ACC_W-1:0]     r_rem;
    logic [DIV_STEPS-1:0] r_quo;
    logic [RATIO_W-1:0]   r_ratio;

    logic [ACC_W-1:0]     w_mag_m;
    logic [ACC_W-1:0]     w_mag_p;
    logic                 w_early;
    logic [ACC_W:0]       w_rem2;
    logic                 w_ge;

    // Magnitudes of the two's complement totals; the most negative value
    // still fits as an unsigned magnitude.
    assign w_mag_m = i_missing[ACC_W-1] ? (~i_missing + ACC_W'(1)) : i_missing;
    assign w_mag_p = i_pair[ACC_W-1] ? (~i_pair + ACC_W'(1)) : i_pair;

    // Zero pairs, zero or opposite-sign quotient, or a quotient of one or
    // more all settle without iterating.
    assign w_early = r_pz || (r_mag_m == '0) || (r_neg_m != r_neg_p) || (r_mag_m >= r_mag_p);

    // The remainder stays below the divisor, so it fits in ACC_W bits.
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_mag_p});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= STEP_DECIDE;
            end else if (r_step == STEP_DECIDE) begin
                if (w_early) begin
                    r_step <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= STEP_W'(DIV_STEPS);
                end
            end else if (r_step != '0) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pz    <= (i_pair == '0);
            r_neg_m <= i_missing[ACC_W-1];
            r_neg_p <= i_pair[ACC_W-1];
            r_mag_m <= w_mag_m;
            r_mag_p <= w_mag_p;
        end else if (r_step == STEP_DECIDE) begin
            r_rem <= r_mag_m;
            r_quo <= '0;
            if (r_pz) begin
                r_ratio <= Q16_ONE;
            end else if ((r_mag_m == '0) || (r_neg_m != r_neg_p)) begin
                r_ratio <= '0;
            end else begin
                r_ratio <= Q16_ONE;
            end
        end else if (r_step != '0) begin
            r_rem <= w_ge ? ACC_W'(w_rem2 - {1'b0, r_mag_p}) : w_rem2[ACC_W-1:0];
            r_quo <= {r_quo[DIV_STEPS-2:0], w_ge};
            if (r_step == STEP_W'(1)) begin
                r_ratio <= RATIO_W'({r_quo[DIV_STEPS-2:0], w_ge});
            end
        end
    end

    assign o_done  = r_done;
    assign o_ratio = r_ratio;

    `SMS_ASSERT(a_ratio_range, i_clk, i_rst_n, o_done |-> (o_ratio <= Q16_ONE), "ratio above 1.0")

endmodule

/* rtl/sample_mask_coverage_stats.sv */
// ----------------------------------------------------------------------------
// sample_mask_coverage_stats
// Throughput: one position beat per cycle while a run is open.
// Counters update from the input register; totals from the tally's registers.
// Last position: ready drops; states WAIT, PREP and the 16-step ratio DIV
// (may end early) precede one result beat per sample per ready cycle.
// Reset (i_rst_n low, synchronous): counters and totals zero, config defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sample_mask_coverage_stats (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Position stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata, lowest bit up: weight[16:0], present_bits[48:17],
    // missing_bits[80:49], zero pad.
    input  logic [sms_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                             i_s_axis_tlast,

    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata, lowest bit up: sample_index[4:0], sample_count[36:5],
    // length_real[68:37], length_weighted[116:69], missing_ratio[133:117],
    // zero pad.
    output logic [sms_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                             o_m_axis_tlast,

    // Configuration writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sms_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are only expected while the block
    // is idle, so every stage reads them live.
    // ------------------------------------------------------------------
    logic             r_cfg_inc_unk;
    logic             r_cfg_og_pres;
    logic [TOT_W-1:0] r_cfg_total;
    logic [TOT_W-1:0] r_cfg_og;
    logic             r_cfg_multi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_inc_unk <= 1'b0;
            r_cfg_og_pres <= 1'b1;
            r_cfg_total   <= TOT_W'(32);
            r_cfg_og      <= TOT_W'(1);
            r_cfg_multi   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INCLUDE_UNKNOWN:  r_cfg_inc_unk <= i_cfg_data[0];
                CFG_OUTGROUP_PRESENT: r_cfg_og_pres <= i_cfg_data[0];
                CFG_TOTAL_SAMPLES:    r_cfg_total   <= i_cfg_data[TOT_W-1:0];
                CFG_OUTGROUP_SAMPLES: r_cfg_og      <= i_cfg_data[TOT_W-1:0];
                CFG_MULTI_POPULATION: r_cfg_multi   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Sample geometry. The sample count is clamped to one through the
    // number of cells, and the outgroup to the sample count; an outgroup
    // of zero leaves the outgroup empty.
    // ------------------------------------------------------------------
    t_geom            w_geom;
    logic [NCELL-1:0] w_use;
    logic [NCELL-1:0] w_top;

    always_comb begin
        w_geom.multi = r_cfg_multi;
        priority if (r_cfg_total == '0) begin
            w_geom.tot = TOT_W'(1);
        end else if (r_cfg_total > TOT_W'(NCELL)) begin
            w_geom.tot = TOT_W'(NCELL);
        end else begin
            w_geom.tot = r_cfg_total;
        end
        w_geom.og  = (r_cfg_og > w_geom.tot) ? w_geom.tot : r_cfg_og;
        w_geom.ing = w_geom.tot - w_geom.og;
        for (int n = 0; n < NCELL; n++) begin
            w_use[n] = (TOT_W'(n) < w_geom.tot);
            w_top[n] = (TOT_W'(n) == (w_geom.tot - TOT_W'(1)));
        end
    end

    // ------------------------------------------------------------------
    // Control state machine.
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic w_s_accept;
    logic w_last_acc;
    logic w_ratio_start;
    logic w_drain_en;
    logic w_load;
    logic w_final;
    logic w_last_done;
    logic w_ratio_done;

    assign w_s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last_acc = w_s_accept && i_s_axis_tlast;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (w_last_acc) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // The last position updates the totals at this edge.
                if (w_last_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_ratio_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_load && w_final) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_ratio_start   = 1'b0;
        w_drain_en      = 1'b0;
        unique case (r_state)
            S_RUN:   o_s_axis_tready = 1'b1;
            S_WAIT:  begin
            end
            S_PREP:  w_ratio_start = 1'b1;
            S_DIV:   begin
            end
            S_DRAIN: w_drain_en = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Position decode and input register. With the outgroup absent, the
    // last sample in use reads as present and never as missing. Missing
    // samples zero the weight unless unknowns are kept.
    // ------------------------------------------------------------------
    t_pos n_s1;
    t_pos r_s1;

    always_comb begin
        logic [BITS_W-1:0] v_pbits;
        logic [BITS_W-1:0] v_mbits;
        logic [NCELL-1:0]  v_pres;
        logic [NCELL-1:0]  v_miss;
        logic [W_W-1:0]    v_w;

        v_pbits = i_s_axis_tdata[W_W +: BITS_W];
        v_mbits = i_s_axis_tdata[W_W + BITS_W +: BITS_W];
        v_pres  = v_pbits[NCELL-1:0] & w_use;
        v_miss  = v_mbits[NCELL-1:0] & w_use;
        if (!r_cfg_og_pres) begin
            v_pres = v_pres | w_top;
            v_miss = v_miss & ~w_top;
        end
        v_w = (!r_cfg_inc_unk && (v_miss != '0)) ? '0 : i_s_axis_tdata[W_W-1:0];

        n_s1.vld    = w_s_accept;
        n_s1.last   = i_s_axis_tlast;
        n_s1.cnt    = (v_w != '0);
        n_s1.weight = v_w;
        n_s1.pres   = v_pres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------------
    // Chain of per-sample counter cells. While counting, each cell adds
    // its own present bit; a single-population run only counts outgroup
    // samples. During the drain every result beat shifts the chain one
    // cell toward cell zero, which feeds the output register.
    // ------------------------------------------------------------------
    t_cell_ctrl       w_cell_ctrl;
    logic [NCELL-1:0] w_inc;
    logic [CNT_W-1:0] w_count    [NCELL];
    logic [CNT_W-1:0] w_chain_in [NCELL];

    always_comb begin
        for (int n = 0; n < NCELL; n++) begin
            w_inc[n] = r_s1.vld && r_s1.cnt && r_s1.pres[n]
                       && (w_geom.multi || (TOT_W'(n) >= w_geom.ing));
        end
        for (int n = 0; n < NCELL - 1; n++) begin
            w_chain_in[n] = w_count[n + 1];
        end
        w_chain_in[NCELL-1] = '0;
    end

    assign w_cell_ctrl.shift = w_load;
    assign w_cell_ctrl.clear = w_load && w_final;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            sms_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_cell_ctrl),
                .i_inc   (w_inc[g]),
                .i_next  (w_chain_in[g]),
                .o_count (w_count[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Group counts and totals, then the ratio divider.
    // ------------------------------------------------------------------
    logic [REAL_W-1:0]  w_real;
    logic [WLEN_W-1:0]  w_wlen;
    logic [ACC_W-1:0]   w_missing;
    logic [ACC_W-1:0]   w_pair;
    logic [RATIO_W-1:0] w_ratio;

    sms_tally u_tally (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pos       (r_s1),
        .i_geom      (w_geom),
        .i_clear     (w_load && w_final),
        .o_last_done (w_last_done),
        .o_real      (w_real),
        .o_wlen      (w_wlen),
        .o_missing   (w_missing),
        .o_pair      (w_pair)
    );

    sms_ratio u_ratio (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_ratio_start),
        .i_missing (w_missing),
        .i_pair    (w_pair),
        .o_done    (w_ratio_done),
        .o_ratio   (w_ratio)
    );

    // ------------------------------------------------------------------
    // Drain and output register. While draining, a result beat loads
    // if the register is empty or its beat is taken in the same cycle.
    // ------------------------------------------------------------------
    logic [TOT_W-1:0]     r_drain_idx;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic                 r_m_last;

    assign w_load  = w_drain_en && (!r_m_valid || i_m_axis_tready);
    assign w_final = (r_drain_idx == (w_geom.tot - TOT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_idx <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (w_load) begin
                r_drain_idx <= w_final ? '0 : (r_drain_idx + TOT_W'(1));
                r_m_valid   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= M_TDATA_W'({w_ratio, w_wlen, w_real, w_count[0],
                                    r_drain_idx[IDX_W-1:0]});
            r_m_last <= w_final;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `SMS_ASSERT(a_last_closes_run, i_clk, i_rst_n, w_last_acc |=> !o_s_axis_tready, "position accepted after the last one")
    `SMS_ASSERT_HI(a_drain_in_range, i_clk, i_rst_n, (r_state != S_DRAIN) || (r_drain_idx < w_geom.tot), "drain index past the samples in use")

endmodule
